/* design/cpu_pll_mult_div_search_unit_assert.svh */
// Assertion macros for the PLL multiplier/divider search unit.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef CPU_PLL_MULT_DIV_SEARCH_UNIT_ASSERT_SVH
`define CPU_PLL_MULT_DIV_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLLSRCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLLSRCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pllsrch_pkg.sv */
// Shared constants, status codes and divider handshake types for the
// PLL search unit. No dependencies.
package pllsrch_pkg;

  localparam int unsigned POST_DIV_MAX = 8;
  localparam int unsigned D_W          = $clog2(POST_DIV_MAX + 2);

  localparam int unsigned REF_W  = 26;
  localparam int unsigned TK_W   = 22;
  localparam int unsigned RK_W   = 17;
  localparam int unsigned MULT_W = 7;
  localparam int unsigned PDIV_W = 4;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned WORD_W = 32;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd2;

  localparam logic [WORD_W-1:0] MULT_MAX    = 32'd108;
  localparam logic [MULT_W-1:0] MULT_FLOOR  = 7'd55;
  localparam logic [WORD_W-1:0] VCO_MIN_2X  = 32'd1296000;  // 2 * 648000
  localparam logic [RK_W-1:0]   KHZ_DIVISOR = 17'd1000;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [RK_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* design/pllsrch_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on pllsrch_pkg.
module pllsrch_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pllsrch_pkg::div_req_t req,
  output pllsrch_pkg::div_rsp_t rsp
);

  logic [pllsrch_pkg::WORD_W-1:0] q_r, q_nxt;
  logic [pllsrch_pkg::RK_W-1:0]   rem_r, rem_nxt;
  logic [pllsrch_pkg::RK_W-1:0]   dvs_r;
  logic [4:0]                     cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic [pllsrch_pkg::RK_W:0]     rem_sh;
  logic                           ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[pllsrch_pkg::WORD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? pllsrch_pkg::RK_W'(rem_sh - {1'b0, dvs_r})
                 : pllsrch_pkg::RK_W'(rem_sh);
    q_nxt   = {q_r[pllsrch_pkg::WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

/* design/pllsrch_mul.sv */
// Shared registered multiplier, 26 x 7 bits, product kept modulo 2^32.
// Depends on pllsrch_pkg.
module pllsrch_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic [pllsrch_pkg::REF_W-1:0]    a,
  input  logic [pllsrch_pkg::MULT_W-1:0]   b,
  output logic [pllsrch_pkg::WORD_W-1:0]   prod_r
);

  logic [pllsrch_pkg::REF_W+pllsrch_pkg::MULT_W-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full[pllsrch_pkg::WORD_W-1:0];
    end
  end

endmodule

/* design/cpu_pll_mult_div_search_unit.sv */
// PLL multiplier / post-divider search, top level.
// Depends on pllsrch_pkg, pllsrch_div and pllsrch_mul.
//
// Command channel: pulse start with in_target_khz while busy is low; the word
//   is taken at that edge and busy stays high until the result word.
// Result channel: out_strobe is high for exactly one cycle with status,
//   multiplier, post divider, actual frequency and error on the out_ ports.
//   The receiver cannot stall; capture the word in that cycle. busy drops
//   with the strobe, so the next command may be issued in the strobe cycle.
// Configuration: cfg_we with cfg_wdata loads the reference in Hz; write it
//   only while busy is low.
// Sequence: one command at a time, paced by the shared restoring divider.
//   The unit first scales the reference to kHz and checks the range; each
//   skipped post divider costs a multiply and a check, each tried one a
//   multiplier quotient, a frequency quotient and a scoring step, plus one
//   more multiply and frequency quotient when the multiplier backs off. The
//   strobe follows the range check for an out-of-range target and comes
//   after the eighth divider at the latest for a full search of eight dividers.
// Reset: synchronous, active low; clears the sequencer, busy and the strobe
//   and loads the reference with 24 MHz.
module cpu_pll_mult_div_search_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pllsrch_pkg::TK_W-1:0]        in_target_khz,
  input  logic                                cfg_we,
  input  logic [pllsrch_pkg::REF_W-1:0]       cfg_wdata,
  output logic                                out_strobe,
  output logic [pllsrch_pkg::ST_W-1:0]        out_status,
  output logic [pllsrch_pkg::MULT_W-1:0]      out_pll_mult,
  output logic [pllsrch_pkg::PDIV_W-1:0]      out_post_div,
  output logic [pllsrch_pkg::WORD_W-1:0]      out_actual_hz,
  output logic [pllsrch_pkg::WORD_W-1:0]      out_error_hz
);

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REFDIV = 4'd1;
  localparam logic [3:0] S_RANGE  = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MCHK   = 4'd4;
  localparam logic [3:0] S_DIVM   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_FSTART = 4'd7;
  localparam logic [3:0] S_DIVF   = 4'd8;
  localparam logic [3:0] S_EVAL   = 4'd9;
  localparam logic [3:0] S_END    = 4'd10;

  logic [3:0]                        state_r;
  logic [pllsrch_pkg::REF_W-1:0]     ref_r;
  logic [pllsrch_pkg::TK_W-1:0]      tk_r;
  logic [pllsrch_pkg::WORD_W-1:0]    thz_r;
  logic [pllsrch_pkg::RK_W-1:0]      rk_r;
  logic [pllsrch_pkg::D_W-1:0]       d_r;
  logic [pllsrch_pkg::MULT_W-1:0]    m_r;
  logic                              dec_r;
  logic [pllsrch_pkg::WORD_W-1:0]    f_r;
  logic                              found_r;
  logic [pllsrch_pkg::MULT_W-1:0]    best_m_r;
  logic [pllsrch_pkg::D_W-1:0]       best_d_r;
  logic [pllsrch_pkg::WORD_W-1:0]    best_f_r;
  logic [pllsrch_pkg::WORD_W-1:0]    min_err_r;
  logic                              busy_r;
  logic                              strobe_r;
  logic [pllsrch_pkg::ST_W-1:0]      status_r;
  logic [pllsrch_pkg::MULT_W-1:0]    mult_out_r;
  logic [pllsrch_pkg::PDIV_W-1:0]    pdiv_out_r;
  logic [pllsrch_pkg::WORD_W-1:0]    act_out_r;
  logic [pllsrch_pkg::WORD_W-1:0]    err_out_r;

  pllsrch_pkg::div_req_t             div_req;
  pllsrch_pkg::div_rsp_t             div_rsp;
  logic                              mul_en;
  logic [pllsrch_pkg::REF_W-1:0]     mul_a;
  logic [pllsrch_pkg::MULT_W-1:0]    mul_b;
  logic [pllsrch_pkg::WORD_W-1:0]    prod_r;

  logic [23:0]                       rk_x108;
  logic [22:0]                       rk_x54;
  logic [22:0]                       hi_lim;
  logic [18:0]                       lo_lim;
  logic [pllsrch_pkg::WORD_W-1:0]    err_cur;
  logic                              accept;

  assign accept = start && !busy_r;

  // Range limits: rk*108/2 and rk*54/16
  assign rk_x108 = 24'(rk_r) * 24'd108;
  assign rk_x54  = 23'(rk_r) * 23'd54;
  assign hi_lim  = rk_x108[23:1];
  assign lo_lim  = rk_x54[22:4];

  assign err_cur = thz_r - f_r;

  // Shared multiplier: 2*target*d for the multiplier estimate, ref*m for
  // the output frequency.
  always_comb begin
    mul_en = (state_r == S_MUL1) || (state_r == S_MUL2);
    if (state_r == S_MUL1) begin
      mul_a = pllsrch_pkg::REF_W'({tk_r, 1'b0});
      mul_b = pllsrch_pkg::MULT_W'(d_r);
    end else begin
      mul_a = ref_r;
      mul_b = m_r;
    end
  end

  pllsrch_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Divider requests: reference to kHz, estimate / rk, product / (2*d)
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = rk_r;
    if (state_r == S_IDLE) begin
      div_req.start    = accept;
      div_req.dividend = pllsrch_pkg::WORD_W'(ref_r);
      div_req.divisor  = pllsrch_pkg::KHZ_DIVISOR;
    end else if (state_r == S_MCHK) begin
      div_req.start = (prod_r >= pllsrch_pkg::VCO_MIN_2X);
    end else if (state_r == S_FSTART) begin
      div_req.start   = 1'b1;
      div_req.divisor = pllsrch_pkg::RK_W'({d_r, 1'b0});
    end
  end

  pllsrch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Reference register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= pllsrch_pkg::REF_W'(24000000);
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            busy_r  <= 1'b1;
            state_r <= S_REFDIV;
          end
        end
        S_REFDIV: begin
          if (div_rsp.done) begin
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (rk_r == '0 || 23'(tk_r) > hi_lim || tk_r < pllsrch_pkg::TK_W'(lo_lim)) begin
            strobe_r <= 1'b1;
            busy_r   <= 1'b0;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          state_r <= (d_r > pllsrch_pkg::D_W'(pllsrch_pkg::POST_DIV_MAX)) ? S_END : S_MCHK;
        end
        S_MCHK: begin
          // skip dividers below ceil(648000/target)
          state_r <= (prod_r >= pllsrch_pkg::VCO_MIN_2X) ? S_DIVM : S_MUL1;
        end
        S_DIVM: begin
          if (div_rsp.done) begin
            state_r <= (div_rsp.quot > pllsrch_pkg::MULT_MAX) ? S_END : S_MUL2;
          end
        end
        S_MUL2: begin
          state_r <= S_FSTART;
        end
        S_FSTART: begin
          state_r <= S_DIVF;
        end
        S_DIVF: begin
          if (div_rsp.done) begin
            if (!dec_r && div_rsp.quot > thz_r) begin
              if (m_r < pllsrch_pkg::MULT_FLOOR) begin
                strobe_r <= 1'b1;
                busy_r   <= 1'b0;
                state_r  <= S_IDLE;
              end else begin
                state_r <= S_MUL2;
              end
            end else begin
              state_r <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          state_r <= (err_cur < min_err_r && err_cur == '0) ? S_END : S_MUL1;
        end
        S_END: begin
          strobe_r <= 1'b1;
          busy_r   <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tk_r  <= in_target_khz;
          thz_r <= pllsrch_pkg::WORD_W'(in_target_khz) * 32'd1000;
        end
      end
      S_REFDIV: begin
        if (div_rsp.done) begin
          rk_r <= div_rsp.quot[pllsrch_pkg::RK_W-1:0];
        end
      end
      S_RANGE: begin
        status_r   <= pllsrch_pkg::ST_RANGE;
        mult_out_r <= '0;
        pdiv_out_r <= '0;
        act_out_r  <= '0;
        err_out_r  <= '0;
        d_r        <= pllsrch_pkg::D_W'(1);
        found_r    <= 1'b0;
        min_err_r  <= '1;
      end
      S_MCHK: begin
        if (prod_r < pllsrch_pkg::VCO_MIN_2X) begin
          d_r <= d_r + pllsrch_pkg::D_W'(1);
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          m_r   <= div_rsp.quot[pllsrch_pkg::MULT_W-1:0];
          dec_r <= 1'b0;
        end
      end
      S_DIVF: begin
        if (div_rsp.done) begin
          f_r <= div_rsp.quot;
          if (!dec_r && div_rsp.quot > thz_r) begin
            if (m_r < pllsrch_pkg::MULT_FLOOR) begin
              status_r   <= pllsrch_pkg::ST_NONE;
              mult_out_r <= '0;
              pdiv_out_r <= '0;
              act_out_r  <= '0;
              err_out_r  <= '0;
            end else begin
              // back the multiplier off by one and recompute
              m_r   <= m_r - pllsrch_pkg::MULT_W'(1);
              dec_r <= 1'b1;
            end
          end
        end
      end
      S_EVAL: begin
        if (err_cur < min_err_r) begin
          best_m_r  <= m_r;
          best_d_r  <= d_r;
          best_f_r  <= f_r;
          min_err_r <= err_cur;
          found_r   <= 1'b1;
        end
        d_r <= d_r + pllsrch_pkg::D_W'(1);
      end
      S_END: begin
        if (found_r) begin
          status_r   <= pllsrch_pkg::ST_OK;
          mult_out_r <= best_m_r;
          pdiv_out_r <= best_d_r[pllsrch_pkg::PDIV_W-1:0];
          act_out_r  <= best_f_r;
          err_out_r  <= min_err_r;
        end else begin
          status_r   <= pllsrch_pkg::ST_NONE;
          mult_out_r <= '0;
          pdiv_out_r <= '0;
          act_out_r  <= '0;
          err_out_r  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy          = busy_r;
  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_pll_mult  = mult_out_r;
  assign out_post_div  = pdiv_out_r;
  assign out_actual_hz = act_out_r;
  assign out_error_hz  = err_out_r;

endmodule

/* design/pllsrch_chk.sv */
// Port-level checker for the PLL search unit, bound to the top level.
// Depends on pllsrch_pkg and cpu_pll_mult_div_search_unit_assert.svh.
`include "cpu_pll_mult_div_search_unit_assert.svh"

module pllsrch_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_strobe,
  input logic [pllsrch_pkg::ST_W-1:0]        out_status,
  input logic [pllsrch_pkg::MULT_W-1:0]      out_pll_mult,
  input logic [pllsrch_pkg::PDIV_W-1:0]      out_post_div,
  input logic [pllsrch_pkg::WORD_W-1:0]      out_actual_hz,
  input logic [pllsrch_pkg::WORD_W-1:0]      out_error_hz
);

  // a taken command word keeps the unit busy
  `PLLSRCH_ASSERT_NEXT(a_cmd_busy, start && !busy, busy, "command word taken but not busy")

  // the result word ends the busy period
  `PLLSRCH_ASSERT_SAME(a_res_idle, out_strobe, !busy, "result word while still busy")

  // error words carry no setting
  `PLLSRCH_ASSERT_SAME(a_err_zero, out_strobe && out_status != pllsrch_pkg::ST_OK, out_pll_mult == '0 && out_post_div == '0 && out_actual_hz == '0 && out_error_hz == '0, "error result carries a setting")

  // a good word carries a nonzero multiplier no larger than 108
  `PLLSRCH_ASSERT_SAME(a_ok_mult, out_strobe && out_status == pllsrch_pkg::ST_OK, out_pll_mult != '0 && out_pll_mult <= 7'd108, "multiplier out of range")

endmodule

bind cpu_pll_mult_div_search_unit pllsrch_chk u_pllsrch_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_pll_mult  (out_pll_mult),
  .out_post_div  (out_post_div),
  .out_actual_hz (out_actual_hz),
  .out_error_hz  (out_error_hz)
);
